### hdl/mrpt_pkg.sv
// Shared types, constants and arithmetic helpers for the 64-bit Miller-Rabin prime test.
`default_nettype none
package mrpt_pkg;

    localparam int NUM_BITS      = 64;
    localparam int WITNESS_COUNT = 7;
    localparam int CNT_W         = $clog2(NUM_BITS);
    localparam int K_W           = $clog2(WITNESS_COUNT);

    typedef logic [NUM_BITS-1:0] t_word;
    typedef logic [CNT_W:0]      t_shift;
    typedef logic [K_W-1:0]      t_base_idx;

    localparam t_base_idx LAST_BASE = t_base_idx'(WITNESS_COUNT - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD3,
        ST_SPLIT,
        ST_BASE,
        ST_BASE_W,
        ST_POW,
        ST_PMUL,
        ST_PSQ,
        ST_CHECK,
        ST_SQ,
        ST_SQW,
        ST_NEXT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic  start;
        t_word x;
        t_word y;
        t_word m;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word p;
    } t_mul_rsp;

    function automatic t_word add_mod(t_word x, t_word y, t_word m);
        t_word room;
        room = m - y;
        return (x >= room) ? (x - room) : (x + y);
    endfunction

    function automatic t_word witness_base(t_base_idx k);
        t_word b;
        unique case (k)
            3'd0:    b = t_word'(2);
            3'd1:    b = t_word'(325);
            3'd2:    b = t_word'(9375);
            3'd3:    b = t_word'(28178);
            3'd4:    b = t_word'(450775);
            3'd5:    b = t_word'(9780504);
            3'd6:    b = t_word'(1795265022);
            default: b = t_word'(2);
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### hdl/mrpt_ifs.sv
// Valid/ready channel interfaces for the number word and the verdict word.
`default_nettype none
interface mrpt_in_if import mrpt_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word n_value;
    modport source (output valid, output n_value, input ready);
    modport sink   (input valid, input n_value, output ready);
endinterface

interface mrpt_out_if;
    logic valid;
    logic ready;
    logic is_prime;
    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

### hdl/mrpt_modmul.sv
// Bit-serial modular multiplier: one double-and-add step mod m per cycle.
`default_nettype none
module mrpt_modmul import mrpt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    t_word              r_acc,  n_acc;
    t_word              r_x,    n_x;
    t_word              r_y,    n_y;
    t_word              r_m,    n_m;
    t_word              w_dbl;

    always_comb begin
        w_dbl  = add_mod(r_acc, r_acc, r_m);
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        n_m    = r_m;
        if (r_busy) begin
            n_acc = r_y[NUM_BITS-1] ? add_mod(w_dbl, r_x, r_m) : w_dbl;
            n_y   = r_y << 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_acc  = '0;
            n_cnt  = CNT_W'(NUM_BITS - 1);
            n_x    = i_req.x;
            n_y    = i_req.y;
            n_m    = i_req.m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_m   <= n_m;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule
`default_nettype wire

### hdl/miller_rabin_prime_test_64_core.sv
// Top level: Miller-Rabin sequencer around the shared modular multiplier.
//  channel | dir | payload           | handshake
//  i_in    | in  | n_value [63:0]    | valid/ready
//  o_out   | out | is_prime          | valid/ready
// A number below 4 or even is settled without the multiplier, and a
// multiple of 3 after one product mod 3. Otherwise every modular product
// runs on the one multiplier: up to 7 bases x (1 + 2*(64-s) + s-1)
// products, at most 127 per base.
// Reset is synchronous and clears the sequencer and the output valid.
// A new word is taken only when the sequencer is idle; the verdict is held
// in an output register, so a stalled sink delays only the next finish.
`default_nettype none
module miller_rabin_prime_test_64_core import mrpt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mrpt_in_if.sink     i_in,
    mrpt_out_if.source  o_out
);

    t_state     r_state, n_state;
    t_word      r_n, n_n;
    t_word      r_nm1, n_nm1;
    t_word      r_d, n_d;
    t_shift     r_s, n_s;
    t_shift     r_r, n_r;
    t_base_idx  r_k, n_k;
    t_word      r_res, n_res;
    t_word      r_b, n_b;
    t_word      r_e, n_e;
    t_word      r_p, n_p;
    logic       r_verdict, n_verdict;
    logic       r_out_valid, n_out_valid;
    logic       r_out_bit, n_out_bit;
    t_mul_req   r_req, n_req;
    t_mul_rsp   w_rsp;
    logic       w_in_ready;
    logic       w_out_free;

    mrpt_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_in_ready = (r_state == ST_IDLE);
        w_out_free = !r_out_valid || o_out.ready;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_nm1       = r_nm1;
        n_d         = r_d;
        n_s         = r_s;
        n_r         = r_r;
        n_k         = r_k;
        n_res       = r_res;
        n_b         = r_b;
        n_e         = r_e;
        n_p         = r_p;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_bit   = r_out_bit;
        n_req       = r_req;
        n_req.start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_n = i_in.n_value;
                    if (i_in.n_value < t_word'(4)) begin
                        n_verdict = (i_in.n_value == t_word'(2)) ||
                                    (i_in.n_value == t_word'(3));
                        n_state   = ST_DONE;
                    end else if (!i_in.n_value[0]) begin
                        n_verdict = 1'b0;
                        n_state   = ST_DONE;
                    end else begin
                        n_req   = '{start: 1'b1, x: t_word'(1), y: i_in.n_value,
                                    m: t_word'(3)};
                        n_state = ST_MOD3;
                    end
                end
            end
            ST_MOD3: begin
                if (w_rsp.done) begin
                    if (w_rsp.p == '0) begin
                        n_verdict = 1'b0;
                        n_state   = ST_DONE;
                    end else begin
                        n_nm1   = r_n - 1'b1;
                        n_d     = r_n - 1'b1;
                        n_s     = '0;
                        n_state = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                if (!r_d[0]) begin
                    n_d = r_d >> 1;
                    n_s = r_s + 1'b1;
                end else begin
                    n_k     = '0;
                    n_state = ST_BASE;
                end
            end
            ST_BASE: begin
                n_req   = '{start: 1'b1, x: t_word'(1), y: witness_base(r_k), m: r_n};
                n_state = ST_BASE_W;
            end
            ST_BASE_W: begin
                if (w_rsp.done) begin
                    if (w_rsp.p == '0) begin
                        n_state = ST_NEXT;
                    end else begin
                        n_b     = w_rsp.p;
                        n_res   = t_word'(1);
                        n_e     = r_d;
                        n_state = ST_POW;
                    end
                end
            end
            ST_POW: begin
                if (r_e == '0) begin
                    n_p     = r_res;
                    n_state = ST_CHECK;
                end else if (r_e[0]) begin
                    n_req   = '{start: 1'b1, x: r_res, y: r_b, m: r_n};
                    n_state = ST_PMUL;
                end else begin
                    n_req   = '{start: 1'b1, x: r_b, y: r_b, m: r_n};
                    n_state = ST_PSQ;
                end
            end
            ST_PMUL: begin
                if (w_rsp.done) begin
                    n_res   = w_rsp.p;
                    n_req   = '{start: 1'b1, x: r_b, y: r_b, m: r_n};
                    n_state = ST_PSQ;
                end
            end
            ST_PSQ: begin
                if (w_rsp.done) begin
                    n_b     = w_rsp.p;
                    n_e     = r_e >> 1;
                    n_state = ST_POW;
                end
            end
            ST_CHECK: begin
                if (r_p == t_word'(1) || r_p == r_nm1) begin
                    n_state = ST_NEXT;
                end else begin
                    n_r     = t_shift'(1);
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                if (r_r < r_s) begin
                    n_req   = '{start: 1'b1, x: r_p, y: r_p, m: r_n};
                    n_state = ST_SQW;
                end else begin
                    n_verdict = 1'b0;
                    n_state   = ST_DONE;
                end
            end
            ST_SQW: begin
                if (w_rsp.done) begin
                    n_p = w_rsp.p;
                    if (w_rsp.p == r_nm1) begin
                        n_state = ST_NEXT;
                    end else if (w_rsp.p == t_word'(1)) begin
                        n_verdict = 1'b0;
                        n_state   = ST_DONE;
                    end else begin
                        n_r     = r_r + 1'b1;
                        n_state = ST_SQ;
                    end
                end
            end
            ST_NEXT: begin
                if (r_k == LAST_BASE) begin
                    n_verdict = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_BASE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_verdict;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready     = w_in_ready;
        o_out.valid    = r_out_valid;
        o_out.is_prime = r_out_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_req.start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_req.start <= n_req.start;
        end
        r_req.x   <= n_req.x;
        r_req.y   <= n_req.y;
        r_req.m   <= n_req.m;
        r_n       <= n_n;
        r_nm1     <= n_nm1;
        r_d       <= n_d;
        r_s       <= n_s;
        r_r       <= n_r;
        r_k       <= n_k;
        r_res     <= n_res;
        r_b       <= n_b;
        r_e       <= n_e;
        r_p       <= n_p;
        r_verdict <= n_verdict;
        r_out_bit <= n_out_bit;
    end

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |-> (r_state == ST_MOD3 || r_state == ST_BASE_W ||
                         r_state == ST_PMUL || r_state == ST_PSQ || r_state == ST_SQW))
        else $error("multiplier started outside a wait state");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_MOD3 || r_state == ST_BASE_W ||
                        r_state == ST_PMUL || r_state == ST_PSQ || r_state == ST_SQW))
        else $error("product arrived with no state waiting for it");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_out_valid) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("verdict not loaded into free output register");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BASE) |-> (r_k <= LAST_BASE))
        else $error("witness index out of range");

endmodule
`default_nettype wire
